// ===== sv/cpcr_pkg.sv =====
package cpcr_pkg;

	// field widths
	localparam int POS_W     = 24;
	localparam int RAD_W     = 16;
	localparam int REST_W    = 9;
	localparam int REST_ONE  = 256;
	localparam int REST_INIT = 230;

	// square root unit: radicand and root widths
	localparam int SQ_IN_W = 50;
	localparam int SQ_RT_W = 25;

	// divider unit: numerator, denominator and quotient widths
	localparam int DIV_NW = 54;
	localparam int DIV_DW = 26;
	localparam int DIV_QW = 27;

	typedef enum logic [1:0] {
		CONTACT_NONE       = 2'd0,
		CONTACT_RESOLVED   = 2'd1,
		CONTACT_COINCIDENT = 2'd2
	} contact_t;

	typedef struct packed {
		logic signed [POS_W-1:0] a_x;
		logic signed [POS_W-1:0] a_y;
		logic signed [POS_W-1:0] a_vx;
		logic signed [POS_W-1:0] a_vy;
		logic [RAD_W-1:0]        a_radius;
		logic                    a_pinned;
		logic signed [POS_W-1:0] b_x;
		logic signed [POS_W-1:0] b_y;
		logic signed [POS_W-1:0] b_vx;
		logic signed [POS_W-1:0] b_vy;
		logic [RAD_W-1:0]        b_radius;
		logic                    b_pinned;
	} cpcr_in_t;

	typedef struct packed {
		logic signed [POS_W-1:0] new_a_x;
		logic signed [POS_W-1:0] new_a_y;
		logic signed [POS_W-1:0] new_a_vx;
		logic signed [POS_W-1:0] new_a_vy;
		logic signed [POS_W-1:0] new_b_x;
		logic signed [POS_W-1:0] new_b_y;
		logic signed [POS_W-1:0] new_b_vx;
		logic signed [POS_W-1:0] new_b_vy;
		contact_t                contact;
	} cpcr_out_t;

endpackage

// ===== sv/circle_pair_collision_response_core.sv =====
// channel      | direction | handshake                        | payload
// pair         | in        | pair_valid / pair_ready          | cpcr_in_t, one circle pair
// resp         | out       | resp_valid / resp_ready          | cpcr_out_t, one response
// restitution  | in        | restitution_we                   | restitution_wdata, 9 bit
//
// one request enters per cycle while the pipeline is not held; each response passes through
// the 25-stage square root and then two banks of 27-stage dividers in series.
// the whole pipeline moves together; while the response register is held by
// resp_ready low, every stage holds and pair_ready is low.
// reset clears all valid bits and loads restitution with 230.
module circle_pair_collision_response_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pair_valid,
	output logic                          pair_ready,
	input  cpcr_pkg::cpcr_in_t            pair,
	output logic                          resp_valid,
	input  logic                          resp_ready,
	output cpcr_pkg::cpcr_out_t           resp,
	input  logic                          restitution_we,
	input  logic [cpcr_pkg::REST_W-1:0]   restitution_wdata
);
	import cpcr_pkg::*;

	localparam int DIFF_W  = POS_W + 1;
	localparam int NEAR_W  = RAD_W + 1;
	localparam int PROD_W  = DIFF_W + NEAR_W + 1;
	localparam int DOT_W   = PROD_W + 1;
	localparam int OV_W    = SQ_RT_W + 1;
	localparam int SCALE_W = REST_W + 1;
	localparam int PUSH_W  = NEAR_W + 1;
	localparam int PNUM_W  = 2 * NEAR_W;
	localparam int INUM_W  = DIV_QW + NEAR_W;
	localparam int PSUM_W  = POS_W + 2;
	localparam int VSUM_W  = DIV_QW + 2;
	localparam logic signed [VSUM_W-1:0] SAT_HI = VSUM_W'((2 ** (POS_W - 1)) - 1);
	localparam logic signed [VSUM_W-1:0] SAT_LO = -VSUM_W'(2 ** (POS_W - 1));

	typedef struct packed {
		cpcr_in_t                 item;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic signed [DOT_W-1:0]  dot;
	} sq_side_t;

	typedef struct packed {
		cpcr_in_t          item;
		logic              neg_x;
		logic              neg_y;
		logic [NEAR_W-1:0] mag_x;
		logic [NEAR_W-1:0] mag_y;
		logic [NEAR_W-1:0] dlen;
		logic              hit;
		logic              zero;
		logic              approach;
	} dv_side_t;

	typedef struct packed {
		cpcr_in_t                item;
		logic signed [POS_W-1:0] ax;
		logic signed [POS_W-1:0] ay;
		logic signed [POS_W-1:0] bx;
		logic signed [POS_W-1:0] by;
		logic                    neg_x;
		logic                    neg_y;
		logic                    hit;
		logic                    zero;
		logic                    approach;
	} im_side_t;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [VSUM_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[POS_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[POS_W-1:0];
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

	logic              adv;
	logic [REST_W-1:0] rest_q;

	// whole pipeline advances unless the response register is held
	assign adv        = !resp_valid || resp_ready;
	assign pair_ready = adv;

	// restitution register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q <= REST_W'(REST_INIT);
		end else if (restitution_we) begin
			rest_q <= restitution_wdata;
		end
	end

	// valid bits
	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [SQ_RT_W-1:0] vld_sq;
	logic [DIV_QW-1:0]  vld_dv;
	logic [DIV_QW-1:0]  vld_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_sq     <= '0;
			vld_s4     <= 1'b0;
			vld_s5     <= 1'b0;
			vld_dv     <= '0;
			vld_s6     <= 1'b0;
			vld_s7     <= 1'b0;
			vld_im     <= '0;
			resp_valid <= 1'b0;
		end else if (adv) begin
			vld_s1     <= pair_valid;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			vld_sq     <= {vld_sq[SQ_RT_W-2:0], vld_s3};
			vld_s4     <= vld_sq[SQ_RT_W-1];
			vld_s5     <= vld_s4;
			vld_dv     <= {vld_dv[DIV_QW-2:0], vld_s5};
			vld_s6     <= vld_dv[DIV_QW-1];
			vld_s7     <= vld_s6;
			vld_im     <= {vld_im[DIV_QW-2:0], vld_s7};
			resp_valid <= vld_im[DIV_QW-1];
		end
	end

	// s1: centre and velocity differences
	cpcr_in_t                 item_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dvx_s1, dvy_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= pair;
			dx_s1   <= DIFF_W'(pair.b_x) - DIFF_W'(pair.a_x);
			dy_s1   <= DIFF_W'(pair.b_y) - DIFF_W'(pair.a_y);
			dvx_s1  <= DIFF_W'(pair.b_vx) - DIFF_W'(pair.a_vx);
			dvy_s1  <= DIFF_W'(pair.b_vy) - DIFF_W'(pair.a_vy);
		end
	end

	// s2: squares and dot product terms
	cpcr_in_t                   item_s2;
	logic signed [DIFF_W-1:0]   dx_s2, dy_s2;
	logic signed [2*DIFF_W-1:0] sqx_s2, sqy_s2;
	logic signed [PROD_W-1:0]   px_s2, py_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2 <= item_s1;
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			sqx_s2  <= dx_s1 * dx_s1;
			sqy_s2  <= dy_s1 * dy_s1;
			px_s2   <= dvx_s1 * $signed(dx_s1[NEAR_W:0]);
			py_s2   <= dvy_s1 * $signed(dy_s1[NEAR_W:0]);
		end
	end

	// s3: squared distance and dot product
	logic [SQ_IN_W-1:0] dsq_s3;
	sq_side_t           side_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			dsq_s3       <= SQ_IN_W'($unsigned(sqx_s2 + sqy_s2));
			side_s3.item <= item_s2;
			side_s3.dx   <= dx_s2;
			side_s3.dy   <= dy_s2;
			side_s3.dot  <= DOT_W'(px_s2) + DOT_W'(py_s2);
		end
	end

	// centre distance
	logic [SQ_RT_W-1:0] dist_rt;
	sq_side_t           sq_line [SQ_RT_W];

	cpcr_isqrt u_isqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (dsq_s3),
		.root (dist_rt)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_line[0] <= side_s3;
			for (int i = 1; i < SQ_RT_W; i++) begin
				sq_line[i] <= sq_line[i-1];
			end
		end
	end

	// s4: overlap, normal magnitudes, push and impulse numerators
	sq_side_t               sq_end;
	logic [OV_W-1:0]        ov;
	logic [DIFF_W-1:0]      abs_x, abs_y;
	logic [DOT_W-1:0]       dot_mag;
	logic [SCALE_W-1:0]     scale;
	dv_side_t               side_s4;
	logic [PNUM_W-1:0]      pnx_s4, pny_s4;
	logic [DIV_NW-1:0]      jn_s4;

	always_comb begin
		sq_end  = sq_line[SQ_RT_W-1];
		ov      = OV_W'(sq_end.item.a_radius) + OV_W'(sq_end.item.b_radius) - OV_W'(dist_rt);
		abs_x   = sq_end.dx[DIFF_W-1] ? $unsigned(-sq_end.dx) : $unsigned(sq_end.dx);
		abs_y   = sq_end.dy[DIFF_W-1] ? $unsigned(-sq_end.dy) : $unsigned(sq_end.dy);
		dot_mag = $unsigned(-sq_end.dot);
		scale   = SCALE_W'(REST_ONE) + SCALE_W'(rest_q);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4.item     <= sq_end.item;
			side_s4.neg_x    <= sq_end.dx[DIFF_W-1];
			side_s4.neg_y    <= sq_end.dy[DIFF_W-1];
			side_s4.mag_x    <= abs_x[NEAR_W-1:0];
			side_s4.mag_y    <= abs_y[NEAR_W-1:0];
			side_s4.dlen     <= dist_rt[NEAR_W-1:0];
			side_s4.hit      <= !ov[OV_W-1] && (ov != '0);
			side_s4.zero     <= (dist_rt == '0);
			side_s4.approach <= sq_end.dot[DOT_W-1];
			pnx_s4           <= PNUM_W'(abs_x[NEAR_W-1:0]) * PNUM_W'(ov[NEAR_W-1:0]);
			pny_s4           <= PNUM_W'(abs_y[NEAR_W-1:0]) * PNUM_W'(ov[NEAR_W-1:0]);
			jn_s4            <= DIV_NW'(dot_mag) * DIV_NW'(scale);
		end
	end

	// s5: half-up rounding offsets and divisors
	dv_side_t          side_s5;
	logic [DIV_NW-1:0] px_num_s5, py_num_s5, j_num_s5;
	logic [DIV_DW-1:0] p_den_s5, j_den_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5   <= side_s4;
			px_num_s5 <= DIV_NW'(pnx_s4) + DIV_NW'(side_s4.dlen);
			py_num_s5 <= DIV_NW'(pny_s4) + DIV_NW'(side_s4.dlen);
			p_den_s5  <= DIV_DW'({side_s4.dlen, 1'b0});
			j_num_s5  <= jn_s4 + DIV_NW'({side_s4.dlen, 8'b0});
			j_den_s5  <= DIV_DW'({side_s4.dlen, 9'b0});
		end
	end

	// push components and impulse magnitude
	logic [DIV_QW-1:0] qpx, qpy, qj;
	dv_side_t          dv_line [DIV_QW];

	cpcr_div u_push_x (.clk(clk), .en(adv), .num(px_num_s5), .den(p_den_s5), .quo(qpx));
	cpcr_div u_push_y (.clk(clk), .en(adv), .num(py_num_s5), .den(p_den_s5), .quo(qpy));
	cpcr_div u_jmag   (.clk(clk), .en(adv), .num(j_num_s5),  .den(j_den_s5), .quo(qj));

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_line[0] <= side_s5;
			for (int i = 1; i < DIV_QW; i++) begin
				dv_line[i] <= dv_line[i-1];
			end
		end
	end

	// s6: corrected positions and impulse numerators
	dv_side_t                dv_end;
	logic signed [PUSH_W:0]  sx, sy;
	logic                    resolved;
	logic                    move_a, move_b;
	im_side_t                side_s6;
	logic [NEAR_W-1:0]       dist_s6;
	logic [INUM_W-1:0]       inx_s6, iny_s6;

	always_comb begin
		dv_end   = dv_line[DIV_QW-1];
		sx       = dv_end.neg_x ? -$signed({1'b0, qpx[PUSH_W-1:0]})
			: $signed({1'b0, qpx[PUSH_W-1:0]});
		sy       = dv_end.neg_y ? -$signed({1'b0, qpy[PUSH_W-1:0]})
			: $signed({1'b0, qpy[PUSH_W-1:0]});
		resolved = dv_end.hit && !dv_end.zero;
		move_a   = resolved && !dv_end.item.a_pinned;
		move_b   = resolved && !dv_end.item.b_pinned;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s6.item     <= dv_end.item;
			side_s6.ax       <= move_a
				? sat_pos(VSUM_W'(PSUM_W'(dv_end.item.a_x) - PSUM_W'(sx))) : dv_end.item.a_x;
			side_s6.ay       <= move_a
				? sat_pos(VSUM_W'(PSUM_W'(dv_end.item.a_y) - PSUM_W'(sy))) : dv_end.item.a_y;
			side_s6.bx       <= move_b
				? sat_pos(VSUM_W'(PSUM_W'(dv_end.item.b_x) + PSUM_W'(sx))) : dv_end.item.b_x;
			side_s6.by       <= move_b
				? sat_pos(VSUM_W'(PSUM_W'(dv_end.item.b_y) + PSUM_W'(sy))) : dv_end.item.b_y;
			side_s6.neg_x    <= dv_end.neg_x;
			side_s6.neg_y    <= dv_end.neg_y;
			side_s6.hit      <= dv_end.hit;
			side_s6.zero     <= dv_end.zero;
			side_s6.approach <= dv_end.approach;
			dist_s6          <= dv_end.dlen;
			inx_s6           <= INUM_W'(qj) * INUM_W'(dv_end.mag_x);
			iny_s6           <= INUM_W'(qj) * INUM_W'(dv_end.mag_y);
		end
	end

	// s7: impulse rounding offsets
	im_side_t          side_s7;
	logic [DIV_NW-1:0] ix_num_s7, iy_num_s7;
	logic [DIV_DW-1:0] i_den_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s7   <= side_s6;
			ix_num_s7 <= DIV_NW'(inx_s6) + DIV_NW'(dist_s6 >> 1);
			iy_num_s7 <= DIV_NW'(iny_s6) + DIV_NW'(dist_s6 >> 1);
			i_den_s7  <= DIV_DW'(dist_s6);
		end
	end

	// impulse components
	logic [DIV_QW-1:0] qix, qiy;
	im_side_t          im_line [DIV_QW];

	cpcr_div u_imp_x (.clk(clk), .en(adv), .num(ix_num_s7), .den(i_den_s7), .quo(qix));
	cpcr_div u_imp_y (.clk(clk), .en(adv), .num(iy_num_s7), .den(i_den_s7), .quo(qiy));

	always_ff @(posedge clk) begin
		if (adv) begin
			im_line[0] <= side_s7;
			for (int i = 1; i < DIV_QW; i++) begin
				im_line[i] <= im_line[i-1];
			end
		end
	end

	// output stage: velocities, contact code, response register
	im_side_t                im_end;
	logic signed [DIV_QW:0]  ix, iy;
	logic                    kick;
	contact_t                contact;

	always_comb begin
		im_end = im_line[DIV_QW-1];
		ix     = im_end.neg_x ? -$signed({1'b0, qix}) : $signed({1'b0, qix});
		iy     = im_end.neg_y ? -$signed({1'b0, qiy}) : $signed({1'b0, qiy});
		kick   = im_end.hit && !im_end.zero && im_end.approach;
		if (!im_end.hit) begin
			contact = CONTACT_NONE;
		end else if (im_end.zero) begin
			contact = CONTACT_COINCIDENT;
		end else begin
			contact = CONTACT_RESOLVED;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			resp.new_a_x  <= im_end.ax;
			resp.new_a_y  <= im_end.ay;
			resp.new_b_x  <= im_end.bx;
			resp.new_b_y  <= im_end.by;
			resp.new_a_vx <= kick
				? sat_pos(VSUM_W'(im_end.item.a_vx) - VSUM_W'(ix)) : im_end.item.a_vx;
			resp.new_a_vy <= kick
				? sat_pos(VSUM_W'(im_end.item.a_vy) - VSUM_W'(iy)) : im_end.item.a_vy;
			resp.new_b_vx <= kick
				? sat_pos(VSUM_W'(im_end.item.b_vx) + VSUM_W'(ix)) : im_end.item.b_vx;
			resp.new_b_vy <= kick
				? sat_pos(VSUM_W'(im_end.item.b_vy) + VSUM_W'(iy)) : im_end.item.b_vy;
			resp.contact  <= contact;
		end
	end

endmodule

// ===== sv/cpcr_isqrt.sv =====
module cpcr_isqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic [cpcr_pkg::SQ_IN_W-1:0]  rad,
	output logic [cpcr_pkg::SQ_RT_W-1:0]  root
);
	import cpcr_pkg::*;

	logic [SQ_IN_W-1:0] rem_s  [SQ_RT_W];
	logic [SQ_RT_W-1:0] root_s [SQ_RT_W];
	logic [SQ_IN_W-1:0] rem_nx  [SQ_RT_W];
	logic [SQ_RT_W-1:0] root_nx [SQ_RT_W];

	// one root bit per stage, msb first, remainder kept as rad - root^2
	always_comb begin
		logic [SQ_IN_W-1:0] rem_in;
		logic [SQ_RT_W-1:0] root_in;
		logic [SQ_IN_W-1:0] trial;
		for (int i = 0; i < SQ_RT_W; i++) begin
			if (i == 0) begin
				rem_in  = rad;
				root_in = '0;
			end else begin
				rem_in  = rem_s[i-1];
				root_in = root_s[i-1];
			end
			trial = (SQ_IN_W'(root_in) << (SQ_RT_W - i))
				+ (SQ_IN_W'(1) << (2 * (SQ_RT_W - 1 - i)));
			if (rem_in >= trial) begin
				rem_nx[i]  = rem_in - trial;
				root_nx[i] = root_in | (SQ_RT_W'(1) << (SQ_RT_W - 1 - i));
			end else begin
				rem_nx[i]  = rem_in;
				root_nx[i] = root_in;
			end
		end
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < SQ_RT_W; i++) begin
				rem_s[i]  <= rem_nx[i];
				root_s[i] <= root_nx[i];
			end
		end
	end

	assign root = root_s[SQ_RT_W-1];

endmodule

// ===== sv/cpcr_div.sv =====
module cpcr_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [cpcr_pkg::DIV_NW-1:0]  num,
	input  logic [cpcr_pkg::DIV_DW-1:0]  den,
	output logic [cpcr_pkg::DIV_QW-1:0]  quo
);
	import cpcr_pkg::*;

	logic [DIV_NW-1:0] rem_s [DIV_QW];
	logic [DIV_DW-1:0] den_s [DIV_QW];
	logic [DIV_QW-1:0] quo_s [DIV_QW];
	logic [DIV_NW-1:0] rem_nx [DIV_QW];
	logic [DIV_QW-1:0] quo_nx [DIV_QW];

	// restoring division, one quotient bit per stage, msb first
	always_comb begin
		logic [DIV_NW-1:0] rem_in;
		logic [DIV_DW-1:0] den_in;
		logic [DIV_QW-1:0] quo_in;
		logic [DIV_NW-1:0] trial;
		for (int i = 0; i < DIV_QW; i++) begin
			if (i == 0) begin
				rem_in = num;
				den_in = den;
				quo_in = '0;
			end else begin
				rem_in = rem_s[i-1];
				den_in = den_s[i-1];
				quo_in = quo_s[i-1];
			end
			trial = DIV_NW'(den_in) << (DIV_QW - 1 - i);
			if (rem_in >= trial) begin
				rem_nx[i] = rem_in - trial;
				quo_nx[i] = quo_in | (DIV_QW'(1) << (DIV_QW - 1 - i));
			end else begin
				rem_nx[i] = rem_in;
				quo_nx[i] = quo_in;
			end
		end
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den;
			for (int i = 0; i < DIV_QW; i++) begin
				rem_s[i] <= rem_nx[i];
				quo_s[i] <= quo_nx[i];
			end
			for (int i = 1; i < DIV_QW; i++) begin
				den_s[i] <= den_s[i-1];
			end
		end
	end

	assign quo = quo_s[DIV_QW-1];

endmodule

// ===== dv/circle_pair_collision_response_core_tb.sv =====
`timescale 1ns / 100ps

module circle_pair_collision_response_core_tb;
	import cpcr_pkg::*;

	localparam int LATENCY   = 87;
	localparam int WDOG_MAX  = 20000;
	localparam int N_RANDOM  = 1630;

	// contact response predictor and store of expected responses
	class contact_scoreboard;
		cpcr_out_t     pending_q[$];
		logic [8:0]    elasticity;
		int            fail_count;

		function new();
			elasticity = 9'(REST_INIT);
			fail_count = 0;
		endfunction

		// integer square root, floor
		function automatic longint unsigned root_floor(longint unsigned v);
			longint unsigned r;
			longint unsigned bitv;
			r = 0;
			bitv = 64'd1 << 62;
			while (bitv > v) bitv >>= 2;
			while (bitv != 0) begin
				if (v >= r + bitv) begin
					v -= r + bitv;
					r = (r >> 1) + bitv;
				end else begin
					r >>= 1;
				end
				bitv >>= 2;
			end
			return r;
		endfunction

		// sign(d) * round-half-up(|d| * m / den)
		function automatic longint signed_share(longint d, longint unsigned m,
				longint unsigned den);
			longint unsigned mag;
			longint q;
			mag = d < 0 ? longint'(-d) : longint'(d);
			q = longint'((mag * m + den / 2) / den);
			return d < 0 ? -q : q;
		endfunction

		function automatic logic signed [23:0] clip24(longint v);
			if (v > 8388607) v = 8388607;
			if (v < -8388608) v = -8388608;
			return v[23:0];
		endfunction

		function automatic cpcr_out_t resolve(cpcr_in_t p);
			cpcr_out_t o;
			longint ax, ay, avx, avy, bx, by, bvx, bvy, dx, dy, ov, sx, sy, dot, ix, iy;
			longint unsigned dsq, dlen, j;
			contact_t c;
			ax = p.a_x; ay = p.a_y; avx = p.a_vx; avy = p.a_vy;
			bx = p.b_x; by = p.b_y; bvx = p.b_vx; bvy = p.b_vy;
			c = CONTACT_NONE;
			dx = bx - ax;
			dy = by - ay;
			dsq = longint'(dx * dx) + longint'(dy * dy);
			dlen = root_floor(dsq);
			ov = longint'(p.a_radius) + longint'(p.b_radius) - longint'(dlen);
			if (ov > 0) begin
				if (dlen == 0) begin
					c = CONTACT_COINCIDENT;
				end else begin
					c = CONTACT_RESOLVED;
					sx = signed_share(dx, ov, 2 * dlen);
					sy = signed_share(dy, ov, 2 * dlen);
					if (!p.a_pinned) begin
						ax -= sx; ay -= sy;
					end
					if (!p.b_pinned) begin
						bx += sx; by += sy;
					end
					dot = (bvx - avx) * dx + (bvy - avy) * dy;
					if (dot < 0) begin
						j = (longint'(-dot) * (256 + elasticity) + 256 * dlen) / (512 * dlen);
						ix = signed_share(dx, j, dlen);
						iy = signed_share(dy, j, dlen);
						avx -= ix; avy -= iy;
						bvx += ix; bvy += iy;
					end
				end
			end
			o.new_a_x = clip24(ax);   o.new_a_y = clip24(ay);
			o.new_a_vx = clip24(avx); o.new_a_vy = clip24(avy);
			o.new_b_x = clip24(bx);   o.new_b_y = clip24(by);
			o.new_b_vx = clip24(bvx); o.new_b_vy = clip24(bvy);
			o.contact = c;
			return o;
		endfunction

		function void note_pair(cpcr_in_t p);
			pending_q.push_back(resolve(p));
		endfunction

		function void check_resp(cpcr_out_t got);
			cpcr_out_t exp_r;
			if (pending_q.size() == 0) begin
				$display("%0t unexpected response %h", $realtime, got);
				fail_count++;
				return;
			end
			exp_r = pending_q.pop_front();
			if (got.new_a_x !== exp_r.new_a_x)
				report("new_a_x", exp_r.new_a_x, got.new_a_x);
			if (got.new_a_y !== exp_r.new_a_y)
				report("new_a_y", exp_r.new_a_y, got.new_a_y);
			if (got.new_a_vx !== exp_r.new_a_vx)
				report("new_a_vx", exp_r.new_a_vx, got.new_a_vx);
			if (got.new_a_vy !== exp_r.new_a_vy)
				report("new_a_vy", exp_r.new_a_vy, got.new_a_vy);
			if (got.new_b_x !== exp_r.new_b_x)
				report("new_b_x", exp_r.new_b_x, got.new_b_x);
			if (got.new_b_y !== exp_r.new_b_y)
				report("new_b_y", exp_r.new_b_y, got.new_b_y);
			if (got.new_b_vx !== exp_r.new_b_vx)
				report("new_b_vx", exp_r.new_b_vx, got.new_b_vx);
			if (got.new_b_vy !== exp_r.new_b_vy)
				report("new_b_vy", exp_r.new_b_vy, got.new_b_vy);
			if (got.contact !== exp_r.contact)
				report("contact", exp_r.contact, got.contact);
		endfunction

		function void report(string fname, longint exp_v, longint got_v);
			$display("%0t mismatch %s expected %h actual %h", $realtime, fname,
				exp_v, got_v);
			fail_count++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        pair_valid;
	logic        pair_ready;
	cpcr_in_t    pair;
	logic        resp_valid;
	logic        resp_ready;
	cpcr_out_t   resp;
	logic        restitution_we;
	logic [REST_W-1:0] restitution_wdata;

	contact_scoreboard sb;
	bit          calm;
	bit          timed_out;
	int          idle_cycles;

	circle_pair_collision_response_core i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.pair_valid        (pair_valid),
		.pair_ready        (pair_ready),
		.pair              (pair),
		.resp_valid        (resp_valid),
		.resp_ready        (resp_ready),
		.resp              (resp),
		.restitution_we    (restitution_we),
		.restitution_wdata (restitution_wdata)
	);

	always #4 clk = ~clk;

	// response side: random stall, check on acceptance
	always @(posedge clk) begin
		if (arst_n && resp_valid && resp_ready)
			sb.check_resp(resp);
		resp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 7);
	end

	// watchdog on cycles with no request or response moving
	always @(posedge clk) begin
		if ((pair_valid && pair_ready) || (resp_valid && resp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX)
			timed_out <= 1'b1;
	end

	// random gap with valid low, then hold the request until accepted
	task automatic send_pair(cpcr_in_t p);
		while (!calm && $urandom_range(0, 99) < 7) begin
			pair_valid <= 1'b0;
			@(posedge clk);
		end
		pair_valid <= 1'b1;
		pair <= p;
		@(posedge clk);
		while (!pair_ready) @(posedge clk);
		sb.note_pair(p);
	endtask

	task automatic drain();
		pair_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic set_elasticity(logic [8:0] v);
		restitution_we <= 1'b1;
		restitution_wdata <= v;
		@(posedge clk);
		sb.elasticity = v;
		restitution_we <= 1'b0;
	endtask

	function automatic logic signed [23:0] rand24();
		return 24'($urandom());
	endfunction

	// mostly small velocities, sometimes full range
	function automatic logic signed [23:0] rand_vel();
		if ($urandom_range(0, 9) == 0)
			return rand24();
		return 24'($signed($urandom_range(0, 8191)) - 4096);
	endfunction

	// nearby pair with a small random offset and random content
	function automatic cpcr_in_t near_pair();
		cpcr_in_t p;
		int span;
		span = (1 << $urandom_range(2, 14));
		p = '0;
		p.a_x = rand24();
		p.a_y = rand24();
		p.b_x = 24'(p.a_x + $signed($urandom_range(0, 2 * span)) - span);
		p.b_y = 24'(p.a_y + $signed($urandom_range(0, 2 * span)) - span);
		p.a_vx = rand_vel();
		p.a_vy = rand_vel();
		p.b_vx = rand_vel();
		p.b_vy = rand_vel();
		p.a_radius = ($urandom_range(0, 7) == 0) ? 16'($urandom())
			: 16'($urandom_range(0, 2 * span));
		p.b_radius = ($urandom_range(0, 7) == 0) ? 16'($urandom())
			: 16'($urandom_range(0, 2 * span));
		p.a_pinned = 1'($urandom());
		p.b_pinned = 1'($urandom());
		return p;
	endfunction

	task automatic directed_pairs();
		cpcr_in_t p;
		// coincident centres with radius
		p = '0; p.a_radius = 16'h0100; p.a_vx = 24'sd512;
		send_pair(p);
		// coincident centres, zero radii
		p = '0; p.a_x = 24'sd1000; p.b_x = 24'sd1000;
		send_pair(p);
		// far apart
		p = '0; p.a_x = -24'sd8388608; p.b_x = 24'sd8388607;
		p.a_radius = 16'hffff; p.b_radius = 16'hffff;
		send_pair(p);
		// head-on approach, both free
		p = '0; p.b_x = 24'sd256; p.a_radius = 16'h0100; p.b_radius = 16'h0100;
		p.a_vx = 24'sd512; p.b_vx = -24'sd512;
		send_pair(p);
		// separating, only positions move
		p.a_vx = -24'sd512; p.b_vx = 24'sd512;
		send_pair(p);
		// resting contact
		p.a_vx = 0; p.b_vx = 0; p.a_vy = 24'sd300; p.b_vy = 24'sd300;
		send_pair(p);
		// pinned pairs on diagonal approach
		p = '0; p.b_x = 24'sd200; p.b_y = -24'sd150; p.a_radius = 16'h0200;
		p.b_radius = 16'h0080; p.a_vx = 24'sd900; p.b_vy = 24'sd700;
		p.a_pinned = 1; send_pair(p);
		p.a_pinned = 0; p.b_pinned = 1; send_pair(p);
		p.a_pinned = 1; send_pair(p);
		// saturation near the positive and negative edges
		p = '0; p.a_x = 24'sd8388600; p.b_x = 24'sd8388607; p.a_y = -24'sd8388608;
		p.b_y = -24'sd8388600; p.a_radius = 16'hffff; p.b_radius = 16'hffff;
		p.a_vx = 24'sd8388607; p.b_vx = -24'sd8388608;
		p.a_vy = -24'sd8388608; p.b_vy = 24'sd8388607;
		send_pair(p);
		p.a_x = -24'sd8388608; p.b_x = -24'sd8388601; send_pair(p);
		// all ones
		p = '1; send_pair(p);
		p.b_x = 24'sd5; send_pair(p);
	endtask

	initial begin
		cpcr_in_t p;
		logic [255:0] raw;
		int k;
		logic [8:0] elast_set[5] = '{9'd0, 9'd256, 9'd511, 9'd128, 9'd230};
		sb = new();
		clk = 0;
		arst_n = 0;
		pair_valid = 0;
		pair = '0;
		resp_ready = 0;
		restitution_we = 0;
		restitution_wdata = '0;
		calm = 0;
		timed_out = 0;
		idle_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_pairs();
		drain();

		for (k = 0; k < N_RANDOM; k++) begin
			// change elasticity between phases, sender waits for all responses
			if (k % 330 == 0) begin
				drain();
				set_elasticity(elast_set[k / 330]);
				calm = (k / 330 == 2);
			end
			raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom()};
			p = ($urandom_range(0, 9) < 8) ? near_pair()
				: cpcr_in_t'(raw[$bits(cpcr_in_t)-1:0]);
			send_pair(p);
		end
		drain();

		if (sb.fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		wait (timed_out);
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
sv/cpcr_pkg.sv
sv/cpcr_isqrt.sv
sv/cpcr_div.sv
sv/circle_pair_collision_response_core.sv
dv/circle_pair_collision_response_core_tb.sv
